// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/core/srf_pkg.sv =====
// ---------------------------------------------------------------------------
// srf_pkg
// Widths, types and register codes of the softened repulsion force block.
// ---------------------------------------------------------------------------
package srf_pkg;
    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int SUM_BITS      = 2 * WORD_BITS + 2;
    localparam int ROOT_BITS     = WORD_BITS + 1;
    localparam int REM_BITS      = ROOT_BITS + 3;
    localparam int SOFT_BITS     = ROOT_BITS + 1;
    localparam int NUM_BITS      = WORD_BITS + 2 * FRAC_BITS;
    localparam int DEN_BITS      = 2 * WORD_BITS;
    localparam int MREM_BITS     = DEN_BITS + 1;
    localparam int UQ_BITS       = FRAC_BITS + 1;
    localparam int UREM_BITS     = ROOT_BITS + 1;
    localparam int PP_BITS       = WORD_BITS + UQ_BITS;
    localparam int PROD_BITS     = NUM_BITS + UQ_BITS;
    localparam int CLIP_BITS     = PROD_BITS - FRAC_BITS;
    localparam int IN_DATA_BITS  = 6 * WORD_BITS;
    localparam int OUT_DATA_BITS = 3 * WORD_BITS;
    localparam int OUT_USER_BITS = 2;
    localparam int USER_COINC    = 0;
    localparam int USER_SAT      = 1;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_STRENGTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOFTENING = 1'd1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [SUM_BITS-1:0]  sum_t;
    typedef logic [ROOT_BITS-1:0] root_t;
    typedef logic [NUM_BITS-1:0]  num_t;
    typedef logic [DEN_BITS-1:0]  den_t;

    localparam word_t STRENGTH_RESET  = 32'd65536;
    localparam word_t SOFTENING_RESET = 32'd6554;
    localparam word_t SAT_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t SAT_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [CLIP_BITS-1:0] NEG_LIM = {{(CLIP_BITS-WORD_BITS){1'b0}}, SAT_NEG};
    localparam logic [CLIP_BITS-1:0] POS_LIM = {{(CLIP_BITS-WORD_BITS){1'b0}}, SAT_POS};

    typedef struct packed {
        word_t [2:0] absd;
        logic  [2:0] neg;
    } isq_side_t;

    typedef struct packed {
        word_t [2:0] absd;
        logic  [2:0] neg;
        root_t       r;
        den_t        ss;
        logic        zero_r;
        logic        big_s;
    } udv_side_t;

    typedef struct packed {
        logic [2:0][UQ_BITS-1:0] u;
        logic [2:0]              neg;
        logic                    zero_r;
        logic                    big_s;
    } mdv_side_t;
endpackage

// ===== rtl/core/softened_repulsion_force_top.sv =====
// ---------------------------------------------------------------------------
// softened_repulsion_force_top
// Softened pairwise repulsion force between two Q16.16 points in 3-D.
// ---------------------------------------------------------------------------
// Takes one pair of points per clock while s_tready is high and returns one
// force per request. A request passes through 122 register stages; the depth
// is set by the 33-stage square root, the 17-stage direction divider and the
// 64-stage magnitude divider. A two-entry output buffer keeps s_tready high
// while one result waits. Coincident points give a zero force with coincident
// set. Configuration writes belong to idle periods only.
`include "assert_macros.svh"

module softened_repulsion_force_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [srf_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [srf_pkg::WORD_BITS-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [srf_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // force_x, force_y, force_z
    output logic [srf_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // coincident, saturated
    output logic [srf_pkg::OUT_USER_BITS-1:0]   m_tuser
);
    import srf_pkg::*;

    logic en;
    word_t strength_reg;
    word_t softening_reg;

    // input differences
    word_t [2:0]              a_w;
    word_t [2:0]              b_w;
    logic  [2:0][WORD_BITS:0] diff;
    logic  [2:0][WORD_BITS:0] dmag;

    logic        s1_v_reg;
    word_t [2:0] s1_absd_reg;
    logic  [2:0] s1_neg_reg;

    logic                     s2_v_reg;
    logic [2:0][DEN_BITS-1:0] s2_sq_reg;
    word_t [2:0]              s2_absd_reg;
    logic  [2:0]              s2_neg_reg;

    logic        s3_v_reg;
    sum_t        s3_sum_reg;
    isq_side_t   s3_side;
    word_t [2:0] s3_absd_reg;
    logic  [2:0] s3_neg_reg;

    logic      sq_v;
    root_t     sq_root;
    isq_side_t sq_side;

    logic                 sa_v_reg;
    logic [SOFT_BITS-1:0] sa_s_reg;
    root_t                sa_r_reg;
    isq_side_t            sa_side_reg;

    logic      sb_v_reg;
    udv_side_t sb_side_reg;

    // direction divider, three lanes
    logic [UQ_BITS-1:0]            uv_in;
    logic [2:0][UREM_BITS-1:0]     urem_in [UQ_BITS];
    logic [2:0][UQ_BITS-1:0]       uq_in [UQ_BITS];
    udv_side_t                     uside_in [UQ_BITS];
    logic [2:0][UREM_BITS-1:0]     ush [UQ_BITS];
    logic [2:0][UREM_BITS-1:0]     urem_next [UQ_BITS];
    logic [2:0][UQ_BITS-1:0]       uq_next [UQ_BITS];
    logic [UQ_BITS-1:0]            uv_reg;
    logic [2:0][UREM_BITS-1:0]     urem_reg [UQ_BITS];
    logic [2:0][UQ_BITS-1:0]       uq_reg [UQ_BITS];
    udv_side_t                     uside_reg [UQ_BITS];

    udv_side_t ud_side;
    mdv_side_t md_in_side;
    logic      md_v;
    num_t      md_quot;
    mdv_side_t md_side;
    num_t      m_eff;

    logic                    m1_v_reg;
    logic [2:0][PP_BITS-1:0] m1_lo_reg;
    logic [2:0][PP_BITS-1:0] m1_hi_reg;
    logic [2:0]              m1_neg_reg;
    logic                    m1_zero_reg;

    logic [2:0][PROD_BITS-1:0] prod;
    logic [2:0][CLIP_BITS-1:0] pmag;
    logic [2:0][CLIP_BITS-1:0] lim;
    logic [2:0]                clip;
    word_t [2:0]               fmag;
    logic [OUT_DATA_BITS-1:0]  res_data;
    logic [OUT_USER_BITS-1:0]  res_user;

    logic                     m2_v_reg;
    logic [OUT_DATA_BITS-1:0] m2_data_reg;
    logic [OUT_USER_BITS-1:0] m2_user_reg;

    logic                     out_v_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [OUT_USER_BITS-1:0] out_user_reg;
    logic                     skid_v_reg;
    logic [OUT_DATA_BITS-1:0] skid_data_reg;
    logic [OUT_USER_BITS-1:0] skid_user_reg;
    logic                     take;
    logic [2:0]               at_lim;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg  <= STRENGTH_RESET;
            softening_reg <= SOFTENING_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_STRENGTH:  strength_reg  <= cfg_wdata;
                REG_SOFTENING: softening_reg <= cfg_wdata;
            endcase
        end
    end

    // stage 1: differences and magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_w[i]  = s_tdata[i*WORD_BITS +: WORD_BITS];
            b_w[i]  = s_tdata[(i+3)*WORD_BITS +: WORD_BITS];
            diff[i] = {a_w[i][WORD_BITS-1], a_w[i]} - {b_w[i][WORD_BITS-1], b_w[i]};
            dmag[i] = diff[i][WORD_BITS] ? ((WORD_BITS+1)'(0) - diff[i]) : diff[i];
        end
    end

    // stages 2 and 3: squares and their sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            sa_v_reg <= 1'b0;
            sb_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_tvalid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            sa_v_reg <= sq_v;
            sb_v_reg <= sa_v_reg;
            m1_v_reg <= md_v;
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_absd_reg[i] <= dmag[i][WORD_BITS-1:0];
                s1_neg_reg[i]  <= diff[i][WORD_BITS];
                s2_sq_reg[i]   <= DEN_BITS'(s1_absd_reg[i]) * DEN_BITS'(s1_absd_reg[i]);
            end
            s2_absd_reg <= s1_absd_reg;
            s2_neg_reg  <= s1_neg_reg;
            s3_sum_reg  <= SUM_BITS'(s2_sq_reg[0]) + SUM_BITS'(s2_sq_reg[1])
                         + SUM_BITS'(s2_sq_reg[2]);
            s3_absd_reg <= s2_absd_reg;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    assign s3_side.absd = s3_absd_reg;
    assign s3_side.neg  = s3_neg_reg;

    srf_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .radicand  (s3_sum_reg),
        .in_side   (s3_side),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // softened distance and its square
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_s_reg    <= SOFT_BITS'(softening_reg) + SOFT_BITS'(sq_root);
            sa_r_reg    <= sq_root;
            sa_side_reg <= sq_side;

            sb_side_reg.absd   <= sa_side_reg.absd;
            sb_side_reg.neg    <= sa_side_reg.neg;
            sb_side_reg.r      <= sa_r_reg;
            sb_side_reg.ss     <= DEN_BITS'(sa_s_reg[WORD_BITS-1:0])
                                * DEN_BITS'(sa_s_reg[WORD_BITS-1:0]);
            sb_side_reg.zero_r <= (sa_r_reg == '0);
            sb_side_reg.big_s  <= |sa_s_reg[SOFT_BITS-1:WORD_BITS];
        end
    end

    // direction divider: |d| * 2^F / r, quotient known to fit UQ_BITS
    assign uv_in[0]    = sb_v_reg;
    assign uq_in[0]    = '0;
    assign uside_in[0] = sb_side_reg;
    for (genvar i = 0; i < 3; i++)
    begin : g_lane0
        assign urem_in[0][i] = UREM_BITS'(sb_side_reg.absd[i][WORD_BITS-1:UQ_BITS-FRAC_BITS]);
    end

    for (genvar k = 1; k < UQ_BITS; k++)
    begin : g_ulink
        assign uv_in[k]    = uv_reg[k-1];
        assign urem_in[k]  = urem_reg[k-1];
        assign uq_in[k]    = uq_reg[k-1];
        assign uside_in[k] = uside_reg[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < UQ_BITS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // only the first step brings in a bit of |d|; the rest are fraction zeros
                ush[k][i] = {urem_in[k][i][UREM_BITS-2:0],
                             (k == 0) && uside_in[k].absd[i][0]};
                if (ush[k][i] >= UREM_BITS'(uside_in[k].r))
                begin
                    urem_next[k][i] = ush[k][i] - UREM_BITS'(uside_in[k].r);
                    uq_next[k][i]   = {uq_in[k][i][UQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    urem_next[k][i] = ush[k][i];
                    uq_next[k][i]   = {uq_in[k][i][UQ_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            uv_reg <= '0;
        else if (en)
            uv_reg <= uv_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < UQ_BITS; k++)
            begin
                urem_reg[k]  <= urem_next[k];
                uq_reg[k]    <= uq_next[k];
                uside_reg[k] <= uside_in[k];
            end
        end
    end

    assign ud_side           = uside_reg[UQ_BITS-1];
    assign md_in_side.u      = uq_reg[UQ_BITS-1];
    assign md_in_side.neg    = ud_side.neg;
    assign md_in_side.zero_r = ud_side.zero_r;
    assign md_in_side.big_s  = ud_side.big_s;

    srf_mdiv u_mdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (uv_reg[UQ_BITS-1]),
        .num       ({strength_reg, (2*FRAC_BITS)'(0)}),
        .den       (ud_side.ss),
        .in_side   (md_in_side),
        .out_valid (md_v),
        .quot      (md_quot),
        .out_side  (md_side)
    );

    // magnitude times direction, split in two partial products
    assign m_eff = md_side.big_s ? '0 : md_quot;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_lo_reg[i] <= PP_BITS'(m_eff[WORD_BITS-1:0]) * PP_BITS'(md_side.u[i]);
                m1_hi_reg[i] <= PP_BITS'(m_eff[NUM_BITS-1:WORD_BITS]) * PP_BITS'(md_side.u[i]);
            end
            m1_neg_reg  <= md_side.neg;
            m1_zero_reg <= md_side.zero_r;
        end
    end

    // clipping and sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = (PROD_BITS'(m1_hi_reg[i]) << WORD_BITS) + PROD_BITS'(m1_lo_reg[i]);
            pmag[i] = prod[i][PROD_BITS-1:FRAC_BITS];
            lim[i]  = m1_neg_reg[i] ? NEG_LIM : POS_LIM;
            clip[i] = (pmag[i] > lim[i]) && !m1_zero_reg;
            fmag[i] = clip[i] ? lim[i][WORD_BITS-1:0] : pmag[i][WORD_BITS-1:0];
            if (m1_zero_reg)
                res_data[i*WORD_BITS +: WORD_BITS] = '0;
            else if (m1_neg_reg[i])
                res_data[i*WORD_BITS +: WORD_BITS] = WORD_BITS'(0) - fmag[i];
            else
                res_data[i*WORD_BITS +: WORD_BITS] = fmag[i];
        end
        res_user             = '0;
        res_user[USER_COINC] = m1_zero_reg;
        res_user[USER_SAT]   = |clip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_data_reg <= res_data;
            m2_user_reg <= res_user;
        end
    end

    // output register with skid entry
    assign take = m_tready || !out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (take)
        begin
            out_v_reg  <= skid_v_reg || m2_v_reg;
            skid_v_reg <= 1'b0;
        end
        else if (en && m2_v_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= skid_v_reg ? skid_data_reg : m2_data_reg;
            out_user_reg <= skid_v_reg ? skid_user_reg : m2_user_reg;
        end
        else if (en)
        begin
            skid_data_reg <= m2_data_reg;
            skid_user_reg <= m2_user_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            at_lim[i] = (m_tdata[i*WORD_BITS +: WORD_BITS] == SAT_POS)
                     || (m_tdata[i*WORD_BITS +: WORD_BITS] == SAT_NEG);
    end

    `ASSERT_IMPLIES(a_coinc_zero, clk, rst_n, m_tvalid && m_tuser[USER_COINC], m_tdata == '0 && !m_tuser[USER_SAT])
    `ASSERT_IMPLIES(a_sat_at_lim, clk, rst_n, m_tvalid && m_tuser[USER_SAT], at_lim != '0)
    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_v_reg, out_v_reg)
    `ASSERT_NEXT(a_skid_kept, clk, rst_n, skid_v_reg && !m_tready, skid_v_reg)
endmodule

// ===== rtl/core/srf_isqrt.sv =====
// ---------------------------------------------------------------------------
// srf_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module srf_isqrt
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  srf_pkg::sum_t     radicand,
    input  srf_pkg::isq_side_t in_side,
    output logic              out_valid,
    output srf_pkg::root_t    root,
    output srf_pkg::isq_side_t out_side
);
    import srf_pkg::*;

    localparam int STAGES = ROOT_BITS;

    logic [STAGES-1:0]   valid_in;
    logic [REM_BITS-1:0] rem_in [STAGES];
    root_t               root_in [STAGES];
    sum_t                num_in [STAGES];
    isq_side_t           side_in [STAGES];

    logic [REM_BITS-1:0] rem_sh [STAGES];
    logic [REM_BITS-1:0] trial [STAGES];
    logic [REM_BITS-1:0] rem_next [STAGES];
    root_t               root_next [STAGES];

    logic [STAGES-1:0]   valid_reg;
    logic [REM_BITS-1:0] rem_reg [STAGES];
    root_t               root_reg [STAGES];
    sum_t                num_reg [STAGES];
    isq_side_t           side_reg [STAGES];

    assign valid_in[0] = in_valid;
    assign rem_in[0]   = '0;
    assign root_in[0]  = '0;
    assign num_in[0]   = radicand;
    assign side_in[0]  = in_side;

    for (genvar k = 1; k < STAGES; k++)
    begin : g_link
        assign valid_in[k] = valid_reg[k-1];
        assign rem_in[k]   = rem_reg[k-1];
        assign root_in[k]  = root_reg[k-1];
        assign num_in[k]   = num_reg[k-1];
        assign side_in[k]  = side_reg[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            rem_sh[k] = {rem_in[k][REM_BITS-3:0], num_in[k][2*(STAGES-1-k) +: 2]};
            trial[k]  = {1'b0, root_in[k], 2'b01};
            if (rem_sh[k] >= trial[k])
            begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_in[k][ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_in[k][ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                num_reg[k]  <= num_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
endmodule

// ===== rtl/core/srf_mdiv.sv =====
// ---------------------------------------------------------------------------
// srf_mdiv
// Pipelined restoring divider for the force magnitude, one bit per stage.
// ---------------------------------------------------------------------------
module srf_mdiv
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  srf_pkg::num_t      num,
    input  srf_pkg::den_t      den,
    input  srf_pkg::mdv_side_t in_side,
    output logic               out_valid,
    output srf_pkg::num_t      quot,
    output srf_pkg::mdv_side_t out_side
);
    import srf_pkg::*;

    localparam int STAGES = NUM_BITS;

    logic [STAGES-1:0]    valid_in;
    logic [MREM_BITS-1:0] rem_in [STAGES];
    num_t                 q_in [STAGES];
    num_t                 num_in [STAGES];
    den_t                 den_in [STAGES];
    mdv_side_t            side_in [STAGES];

    logic [MREM_BITS-1:0] rem_sh [STAGES];
    logic [MREM_BITS-1:0] rem_next [STAGES];
    num_t                 q_next [STAGES];

    logic [STAGES-1:0]    valid_reg;
    logic [MREM_BITS-1:0] rem_reg [STAGES];
    num_t                 q_reg [STAGES];
    num_t                 num_reg [STAGES];
    den_t                 den_reg [STAGES];
    mdv_side_t            side_reg [STAGES];

    assign valid_in[0] = in_valid;
    assign rem_in[0]   = '0;
    assign q_in[0]     = '0;
    assign num_in[0]   = num;
    assign den_in[0]   = den;
    assign side_in[0]  = in_side;

    for (genvar k = 1; k < STAGES; k++)
    begin : g_link
        assign valid_in[k] = valid_reg[k-1];
        assign rem_in[k]   = rem_reg[k-1];
        assign q_in[k]     = q_reg[k-1];
        assign num_in[k]   = num_reg[k-1];
        assign den_in[k]   = den_reg[k-1];
        assign side_in[k]  = side_reg[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            rem_sh[k] = {rem_in[k][DEN_BITS-1:0], num_in[k][STAGES-1-k]};
            if (rem_sh[k] >= {1'b0, den_in[k]})
            begin
                rem_next[k] = rem_sh[k] - {1'b0, den_in[k]};
                q_next[k]   = {q_in[k][NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[k];
                q_next[k]   = {q_in[k][NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                num_reg[k]  <= num_in[k];
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quot      = q_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
endmodule

// ===== tb/srf_force_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srf_force_checker
// Watches the config port and both streams of the repulsion force block.
// Each accepted point pair is turned into an expected force from a local
// copy of the strength and softening registers. Each returned force is
// compared field by field with the oldest expected one.
// ---------------------------------------------------------------------------
module srf_force_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [srf_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [srf_pkg::WORD_BITS-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [srf_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // force_x, force_y, force_z
    input  logic [srf_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // coincident, saturated
    input  logic [srf_pkg::OUT_USER_BITS-1:0]   m_tuser,
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import srf_pkg::*;

    typedef struct packed {
        word_t [2:0] force_v;
        logic        coincident;
        logic        saturated;
    } force_t;

    word_t  strength;
    word_t  softening;
    force_t force_queue[$];

    function automatic force_t predict_force(logic [IN_DATA_BITS-1:0] pair,
                                             word_t str, word_t eps);
        logic [32:0]  d;
        logic [32:0]  absd [3];
        logic         neg [3];
        logic [65:0]  sumsq;
        logic [33:0]  root;
        logic [33:0]  cand;
        logic [67:0]  csq;
        logic [34:0]  s;
        logic [63:0]  m;
        logic [63:0]  u;
        logic [63:0]  p;
        logic [63:0]  lim;
        logic [127:0] prod;
        force_t       f;
        f = '0;
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = {pair[i*32+31], pair[i*32 +: 32]} - {pair[(i+3)*32+31], pair[(i+3)*32 +: 32]};
            neg[i] = d[32];
            absd[i] = neg[i] ? -d : d;
            sumsq = sumsq + 66'(absd[i]) * 66'(absd[i]);
        end
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = root | (34'd1 << b);
            csq = 68'(cand) * 68'(cand);
            if (csq <= 68'(sumsq))
                root = cand;
        end
        if (root == 0)
        begin
            f.coincident = 1'b1;
            return f;
        end
        s = 35'(eps) + 35'(root);
        if (s[34:32] != 0)
            m = '0;
        else
            m = {str, 32'd0} / ({32'd0, s[31:0]} * {32'd0, s[31:0]});
        for (int i = 0; i < 3; i++)
        begin
            u = ({31'd0, absd[i]} << FRAC_BITS) / {30'd0, root};
            lim = neg[i] ? 64'h8000_0000 : 64'h7FFF_FFFF;
            prod = 128'(m) * 128'(u);
            if (u == 0 || m == 0)
                p = '0;
            else if (prod[127:64] != 0)
            begin
                p = lim;
                f.saturated = 1'b1;
            end
            else
            begin
                p = prod[79:16];
                if (p > lim)
                begin
                    p = lim;
                    f.saturated = 1'b1;
                end
            end
            f.force_v[i] = neg[i] ? -p[31:0] : p[31:0];
        end
        return f;
    endfunction

    assign pending_count = force_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        force_t want;
        force_t got;
        if (!rst_n)
        begin
            strength <= STRENGTH_RESET;
            softening <= SOFTENING_RESET;
            force_queue.delete();
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_addr == REG_STRENGTH)
                    strength <= cfg_wdata;
                else if (cfg_addr == REG_SOFTENING)
                    softening <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
                force_queue.push_back(predict_force(s_tdata, strength, softening));
            if (m_tvalid && m_tready)
            begin
                got.force_v = m_tdata;
                got.coincident = m_tuser[USER_COINC];
                got.saturated = m_tuser[USER_SAT];
                if (force_queue.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t unexpected force %h/%b%b", $realtime,
                                 got.force_v, got.coincident, got.saturated);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = force_queue.pop_front();
                    if (got != want)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t force mismatch: exp x=%h y=%h z=%h c=%b s=%b, got x=%h y=%h z=%h c=%b s=%b",
                                     $realtime, want.force_v[0], want.force_v[1],
                                     want.force_v[2], want.coincident, want.saturated,
                                     got.force_v[0], got.force_v[1], got.force_v[2],
                                     got.coincident, got.saturated);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_softened_repulsion_force_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_softened_repulsion_force_top
// Stimulus and verdict for the softened repulsion force block.
// Directed point pairs, then phases of random pairs under several strength
// and softening settings, with random gaps on both streams, a stall-free
// stretch and one long output stall. Checking lives in srf_force_checker.
// ---------------------------------------------------------------------------
module tb_softened_repulsion_force_top;
    import srf_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]    cfg_addr;
    logic [WORD_BITS-1:0]       cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_DATA_BITS-1:0]    s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_DATA_BITS-1:0]   m_tdata;
    logic [OUT_USER_BITS-1:0]   m_tuser;
    int                         mismatch_count;
    int                         pending_count;
    int                         src_idle_pct;
    int                         sink_idle_pct;
    bit                         hold_req;
    int                         cycle_count;

    softened_repulsion_force_top u_dut (.*);

    srf_force_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 200000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (500) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            @(posedge clk);
        end
    end

    function automatic logic [IN_DATA_BITS-1:0] make_pair(word_t a [3], word_t b [3]);
        return {b[2], b[1], b[0], a[2], a[1], a[0]};
    endfunction

    function automatic logic [IN_DATA_BITS-1:0] random_pair();
        word_t a [3];
        word_t b [3];
        word_t delta;
        int    sel;
        int    k;
        sel = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++)
        begin
            a[i] = $urandom;
            if (sel < 6)
                b[i] = a[i];
            else if (sel < 25)
                b[i] = $urandom;
            else
            begin
                k = $urandom_range(0, 32);
                delta = (k == 32) ? $urandom : ($urandom & ((32'd1 << k) - 1));
                if ($urandom_range(0, 1))
                    delta = -delta;
                b[i] = a[i] - delta;
            end
        end
        return make_pair(a, b);
    endfunction

    task automatic send_pair(logic [IN_DATA_BITS-1:0] pair);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pair;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic set_config(word_t str, word_t eps);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_STRENGTH;
        cfg_wdata <= str;
        @(posedge clk);
        cfg_addr <= REG_SOFTENING;
        cfg_wdata <= eps;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_pair(random_pair());
    endtask

    initial
    begin
        word_t a [3];
        word_t b [3];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_STRENGTH;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_req = 1'b0;
        src_idle_pct = 34;
        sink_idle_pct = 34;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings
        a = '{32'h0, 32'h0, 32'h0};
        send_pair(make_pair(a, a));
        a = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        send_pair(make_pair(a, a));
        b = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        send_pair(make_pair(a, b));
        send_pair(make_pair(b, a));
        a = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        b = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_pair(make_pair(a, b));
        send_pair(make_pair(b, a));
        a = '{32'h1, 32'h0, 32'h0};
        b = '{32'h0, 32'h0, 32'h0};
        send_pair(make_pair(a, b));
        send_pair(make_pair(b, a));
        a = '{32'h0, 32'h0001_0000, 32'h0};
        send_pair(make_pair(a, b));
        a = '{32'h0, 32'h0, 32'hFFFF_0000};
        send_pair(make_pair(a, b));
        a = '{32'h0003_0000, 32'hFFFC_0000, 32'h0};
        send_pair(make_pair(a, b));
        a = '{32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000};
        send_pair(make_pair(a, b));
        a = '{32'h0064_0000, 32'h0, 32'h0};
        send_pair(make_pair(a, b));
        drain();

        set_config(32'hFFFF_FFFF, 32'h0);
        a = '{32'h1, 32'h1, 32'hFFFF_FFFF};
        send_pair(make_pair(a, b));
        a = '{32'h0010_0000, 32'h0, 32'h0};
        send_pair(make_pair(a, b));
        a = '{32'h7FFF_FFFF, 32'h0, 32'h0};
        b = '{32'h8000_0000, 32'h0, 32'h0};
        send_pair(make_pair(a, b));
        run_random(280);
        drain();

        set_config(32'h0, 32'hFFFF_FFFF);
        a = '{32'h5, 32'h0, 32'h0};
        b = '{32'h0, 32'h0, 32'h0};
        send_pair(make_pair(a, b));
        run_random(250);
        drain();

        set_config(32'h0001_0000, 32'hFFFF_FFFF);
        send_pair(make_pair(a, b));
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random(300);
        drain();

        set_config($urandom, $urandom_range(0, 32'h0002_0000));
        src_idle_pct = 0;
        sink_idle_pct = 34;
        hold_req = 1'b1;
        run_random(300);
        src_idle_pct = 34;
        drain();

        set_config(32'h0100_0000, 32'h0);
        run_random(300);
        drain();

        set_config($urandom, $urandom);
        run_random(300);
        drain();

        if (mismatch_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
